// ===== design/apc_pkg.sv =====
// apc_pkg: shared constants, codes, FSM state and control/status structs
// for the AUC placement counter. No dependencies.
package apc_pkg;

  // Geometry of the reference store
  localparam int MAX_REF     = 1024;
  localparam int MAX_MARKERS = 8;

  // Field widths
  localparam int MARKER_W = $clog2(MAX_MARKERS);
  localparam int SLOT_W   = $clog2(MAX_REF);
  localparam int SCORE_W  = 32;
  localparam int CNT_W    = 11;
  localparam int SUM_W    = 12;
  localparam int ADDR_W   = MARKER_W + SLOT_W;
  localparam int MEM_DEPTH = MAX_MARKERS * MAX_REF;

  // APB port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_REF_COUNT = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } apc_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic wr;     // store a reference beat
    logic start;  // latch a query beat
    logic issue;  // read next reference
    logic push;   // load output register
  } apc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic n_zero;
    logic last_issue;
    logic out_free;
  } apc_stat_t;

endpackage

// ===== design/apc_if.sv =====
// apc_if: valid/ready channel interfaces for input items and results.
// Depends on apc_pkg.
interface apc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [apc_pkg::MARKER_W-1:0]         marker;
  logic [apc_pkg::SLOT_W-1:0]           ref_slot;
  logic signed [apc_pkg::SCORE_W-1:0]   score;

  modport source (output valid, cmd, marker, ref_slot, score, input ready);
  modport sink   (input valid, cmd, marker, ref_slot, score, output ready);
endinterface

interface apc_out_if;
  logic                           valid;
  logic                           ready;
  logic [apc_pkg::MARKER_W-1:0]   marker_out;
  logic [apc_pkg::SUM_W-1:0]      placement_half;

  modport source (output valid, marker_out, placement_half, input ready);
  modport sink   (input valid, marker_out, placement_half, output ready);
endinterface

// ===== design/apc_cfg.sv =====
// apc_cfg: APB register block holding direction_greater and ref_count.
// Depends on apc_pkg.
module apc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apc_pkg::PADDR_W-1:0]   paddr,
  input  logic [apc_pkg::PDATA_W-1:0]   pwdata,
  output logic [apc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic                          direction,
  output logic [apc_pkg::CNT_W-1:0]     ref_count
);

  logic                        direction_r;
  logic [apc_pkg::CNT_W-1:0]   ref_count_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      ref_count_r <= apc_pkg::CNT_W'(1);
    end else if (wr_en) begin
      case (paddr[2])
        apc_pkg::REG_DIRECTION: direction_r <= pwdata[0];
        apc_pkg::REG_REF_COUNT: ref_count_r <= pwdata[apc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      apc_pkg::REG_DIRECTION: prdata = apc_pkg::PDATA_W'(direction_r);
      apc_pkg::REG_REF_COUNT: prdata = apc_pkg::PDATA_W'(ref_count_r);
      default:                prdata = '0;
    endcase
  end

  assign direction = direction_r;
  assign ref_count = ref_count_r;

endmodule

// ===== design/apc_ctrl.sv =====
// apc_ctrl: controller FSM sequencing loads, reference reads and result push.
// Depends on apc_pkg.
module apc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  apc_pkg::apc_stat_t  stat,
  output logic                in_ready,
  output apc_pkg::apc_cmd_t   cmd
);

  apc_pkg::apc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= apc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      apc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == apc_pkg::CMD_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = apc_pkg::ST_RUN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      apc_pkg::ST_RUN: begin
        if (stat.n_zero) begin
          state_nxt = apc_pkg::ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (stat.last_issue) state_nxt = apc_pkg::ST_DRAIN;
        end
      end
      // last compare lands in the accumulator
      apc_pkg::ST_DRAIN: state_nxt = apc_pkg::ST_FINISH;
      apc_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = apc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = apc_pkg::ST_IDLE;
    endcase
  end

  a_query_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == apc_pkg::CMD_QUERY) |=> state_r == apc_pkg::ST_RUN)
    else $error("query beat did not start a run");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> state_r == apc_pkg::ST_IDLE)
    else $error("load beat left idle");

endmodule

// ===== design/apc_dp.sv =====
// apc_dp: reference store, compare/accumulate datapath and output register.
// Depends on apc_pkg.
module apc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  apc_pkg::apc_cmd_t                   cmd,
  output apc_pkg::apc_stat_t                  stat,
  input  logic [apc_pkg::MARKER_W-1:0]        in_marker,
  input  logic [apc_pkg::SLOT_W-1:0]          in_slot,
  input  logic signed [apc_pkg::SCORE_W-1:0]  in_score,
  input  logic                                direction,
  input  logic [apc_pkg::CNT_W-1:0]           ref_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [apc_pkg::MARKER_W-1:0]        out_marker,
  output logic [apc_pkg::SUM_W-1:0]           out_half
);

  localparam logic [apc_pkg::CNT_W-1:0] MaxRefCnt = apc_pkg::CNT_W'(apc_pkg::MAX_REF);

  logic [apc_pkg::SCORE_W-1:0]        mem [apc_pkg::MEM_DEPTH];

  logic signed [apc_pkg::SCORE_W-1:0] q_score_r;
  logic [apc_pkg::MARKER_W-1:0]       q_marker_r;
  logic [apc_pkg::CNT_W-1:0]          n_r;
  logic [apc_pkg::SLOT_W-1:0]         idx_r;
  logic [apc_pkg::SCORE_W-1:0]        rd_data_r;
  logic                               rd_vld_r;
  logic [apc_pkg::SUM_W-1:0]          acc_r;
  logic [apc_pkg::SUM_W-1:0]          acc_nxt;
  logic                               out_valid_r;
  logic [apc_pkg::MARKER_W-1:0]       out_marker_r;
  logic [apc_pkg::SUM_W-1:0]          out_half_r;
  logic [apc_pkg::CNT_W-1:0]          n_eff;
  logic signed [apc_pkg::SCORE_W-1:0] ref_s;
  logic                               win;
  logic                               tie;

  // clamp ref_count to the store depth
  assign n_eff = (ref_count > MaxRefCnt) ? MaxRefCnt : ref_count;

  // reference store: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[{in_marker, in_slot}] <= in_score;
    if (cmd.issue) rd_data_r <= mem[{q_marker_r, idx_r}];
  end

  // query context and read index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.start)      idx_r <= '0;
      else if (cmd.issue) idx_r <= idx_r + apc_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_score_r  <= in_score;
      q_marker_r <= in_marker;
      n_r        <= n_eff;
    end
  end

  // compare one reference against the query, 2 per win, 1 per tie
  assign ref_s = $signed(rd_data_r);
  assign win   = direction ? (ref_s > q_score_r) : (ref_s < q_score_r);
  assign tie   = (ref_s == q_score_r);

  always_comb begin
    acc_nxt = acc_r;
    if (rd_vld_r) begin
      if (win)      acc_nxt = acc_r + apc_pkg::SUM_W'(2);
      else if (tie) acc_nxt = acc_r + apc_pkg::SUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) acc_r <= '0;
    else           acc_r <= acc_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_marker_r <= q_marker_r;
      out_half_r   <= acc_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_marker = out_marker_r;
  assign out_half   = out_half_r;

  // status back to the controller
  assign stat.n_zero     = (n_r == '0);
  assign stat.last_issue = ({1'b0, idx_r} == (n_r - apc_pkg::CNT_W'(1)));
  assign stat.out_free   = !out_valid_r || out_ready;

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> ({1'b0, idx_r} < n_r))
    else $error("reference read beyond ref_count");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (acc_r <= {n_r, 1'b0}))
    else $error("placement sum exceeds twice the reference count");

  a_push_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !rd_vld_r && !cmd.issue)
    else $error("result pushed with a compare still pending");

  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken beat");

endmodule

// ===== design/auc_placement_counter_top.sv =====
// Timing: a load beat is written at its accept edge; a query beat reads
// n = min(ref_count, 1024) references, one store read per cycle in RUN,
// then passes DRAIN and FINISH into the output register (ref_count 0 goes
// from RUN straight to FINISH). Throughput: loads one per cycle while idle;
// after a query, the next beat waits until its result is pushed to the output.
// Reset (rst_n, synchronous): direction_greater 0, ref_count 1, channels idle;
// reference store contents undefined until loaded.
module auc_placement_counter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  apc_in_if.sink                        in_ch,
  apc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apc_pkg::PADDR_W-1:0]   paddr,
  input  logic [apc_pkg::PDATA_W-1:0]   pwdata,
  output logic [apc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  apc_pkg::apc_cmd_t           cmd;
  apc_pkg::apc_stat_t          stat;
  logic                        direction;
  logic [apc_pkg::CNT_W-1:0]   ref_count;

  // configuration registers
  apc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .direction (direction),
    .ref_count (ref_count)
  );

  // sequencer
  apc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // store, compare and output register
  apc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_marker  (in_ch.marker),
    .in_slot    (in_ch.ref_slot),
    .in_score   (in_ch.score),
    .direction  (direction),
    .ref_count  (ref_count),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_marker (out_ch.marker_out),
    .out_half   (out_ch.placement_half)
  );

endmodule

// ===== tb/auc_placement_counter_top_tb.sv =====
// Self-checking testbench for auc_placement_counter_top: loads reference scores,
// queries placements and checks every result against a scoreboard predictor.
// Depends on apc_pkg, apc_if and the auc_placement_counter_top RTL.

typedef struct packed {
  logic [apc_pkg::MARKER_W-1:0] marker;
  logic [apc_pkg::SUM_W-1:0]    half;
} placement_t;

// Scoreboard: own copy of the reference store and registers, queue of
// placements still owed by the block.
class placement_scoreboard;
  logic [apc_pkg::SCORE_W-1:0] ref_store [apc_pkg::MEM_DEPTH];
  bit                          slot_loaded [apc_pkg::MEM_DEPTH];
  bit                          dir_greater;
  logic [apc_pkg::CNT_W-1:0]   ref_cnt;
  placement_t                  pending_placements [$];
  int                          errors;

  function new();
    dir_greater = 1'b0;
    ref_cnt     = 1;
    errors      = 0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
  endfunction

  task report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function void set_reg(input logic idx, input logic [31:0] val);
    if (idx == apc_pkg::REG_DIRECTION) dir_greater = val[0];
    else ref_cnt = val[apc_pkg::CNT_W-1:0];
  endfunction

  function logic [31:0] reg_value(input logic idx);
    if (idx == apc_pkg::REG_DIRECTION) return {31'b0, dir_greater};
    return {{(32 - apc_pkg::CNT_W){1'b0}}, ref_cnt};
  endfunction

  // True when the first n slots of marker m hold loaded scores
  function bit marker_loaded(input int m, input int n);
    int lim;
    lim = (n > apc_pkg::MAX_REF) ? apc_pkg::MAX_REF : n;
    for (int k = 0; k < lim; k++)
      if (!slot_loaded[m * apc_pkg::MAX_REF + k]) return 1'b0;
    return 1'b1;
  endfunction

  // Accepted input beat: update the store, or predict the placement
  function void accept_item(input logic cmd, input logic [apc_pkg::MARKER_W-1:0] m,
                            input logic [apc_pkg::SLOT_W-1:0] slot,
                            input logic [apc_pkg::SCORE_W-1:0] score);
    int unsigned                 lim;
    int unsigned                 sum;
    logic signed [apc_pkg::SCORE_W-1:0] r;
    logic signed [apc_pkg::SCORE_W-1:0] q;
    bit                          win;
    placement_t                  p;
    if (cmd == apc_pkg::CMD_LOAD) begin
      ref_store[m * apc_pkg::MAX_REF + slot]   = score;
      slot_loaded[m * apc_pkg::MAX_REF + slot] = 1'b1;
      return;
    end
    lim = (ref_cnt > apc_pkg::MAX_REF) ? apc_pkg::MAX_REF : ref_cnt;
    q   = score;
    sum = 0;
    for (int unsigned k = 0; k < lim; k++) begin
      r   = ref_store[m * apc_pkg::MAX_REF + k];
      win = dir_greater ? (r > q) : (r < q);
      if (win) sum += 2;
      else if (r == q) sum += 1;
    end
    if (sum > 4095) sum = 4095;
    p.marker = m;
    p.half   = sum[apc_pkg::SUM_W-1:0];
    pending_placements.push_back(p);
  endfunction

  // Accepted result beat: compare with the oldest prediction
  task check_placement(input logic [apc_pkg::MARKER_W-1:0] m,
                       input logic [apc_pkg::SUM_W-1:0] half);
    placement_t exp_p;
    if (pending_placements.size() == 0) begin
      report($sformatf("unexpected result marker %0d half %0d", m, half));
      return;
    end
    exp_p = pending_placements.pop_front();
    if (m !== exp_p.marker)
      report($sformatf("marker_out %0d, want %0d", m, exp_p.marker));
    if (half !== exp_p.half)
      report($sformatf("placement_half %0d, want %0d (marker %0d)", half, exp_p.half,
                       exp_p.marker));
  endtask
endclass

module auc_placement_counter_top_tb;

  localparam logic [31:0] SCORE_MIN   = 32'h8000_0000;
  localparam logic [31:0] SCORE_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SCORE_FIVE  = 32'h0005_0000;
  localparam int          FILL        = 24;    // slots loaded on every marker
  localparam int          HOLD_CYCLES = 300;
  localparam int          NUM_PHASES  = 9;
  localparam int          PHASE_ITEMS = 40;
  localparam int          PHASE_REF_COUNT [NUM_PHASES] = '{1, 24, 7, 20, 0, 13, 24, 17, 3};

  logic                              clk;
  logic                              rst_n;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [apc_pkg::PADDR_W-1:0]       paddr;
  logic [apc_pkg::PDATA_W-1:0]       pwdata;
  logic [apc_pkg::PDATA_W-1:0]       prdata;
  logic                              pready;

  apc_in_if  in_ch ();
  apc_out_if out_ch ();

  placement_scoreboard sb = new();

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  logic        sink_hold;

  auc_placement_counter_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock, period 2
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Score mix: extremes, small values that tie often, full random
  function automatic logic [31:0] pick_score();
    case ($urandom_range(9))
      0: return SCORE_MIN;
      1: return SCORE_MAX;
      2, 3, 4: return (32'($urandom_range(8)) - 32'd4) << 16;
      5: return 32'($urandom_range(4)) - 32'd2;
      default: return $urandom();
    endcase
  endfunction

  // Offer one beat, with random gaps ahead of it; valid stays high afterwards
  task automatic send_item(input logic c, input logic [apc_pkg::MARKER_W-1:0] m,
                           input logic [apc_pkg::SLOT_W-1:0] s,
                           input logic [apc_pkg::SCORE_W-1:0] sc);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.marker   <= m;
    in_ch.ref_slot <= s;
    in_ch.score    <= sc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.accept_item(c, m, s, sc);
  endtask

  // Random beat: loads mostly into slots in use, queries only on loaded markers
  task automatic random_item(input int n);
    logic [apc_pkg::MARKER_W-1:0] m;
    logic [apc_pkg::SLOT_W-1:0]   s;
    m = apc_pkg::MARKER_W'($urandom_range(apc_pkg::MAX_MARKERS - 1));
    if (($urandom_range(99) < 35) || !sb.marker_loaded(m, n)) begin
      s = ($urandom_range(3) == 0) ? apc_pkg::SLOT_W'($urandom_range(apc_pkg::MAX_REF - 1))
                                   : apc_pkg::SLOT_W'($urandom_range(FILL - 1));
      send_item(apc_pkg::CMD_LOAD, m, s, pick_score());
    end else begin
      send_item(apc_pkg::CMD_QUERY, m, apc_pkg::SLOT_W'($urandom()), pick_score());
    end
  endtask

  // Stop offering and wait until the block is idle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_placements.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write, then read back
  task automatic cfg_set(input logic idx, input logic [31:0] val);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got !== sb.reg_value(idx))
      sb.report($sformatf("register %0d reads %0h, want %0h", idx, got, sb.reg_value(idx)));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: check accepted beats, stall at random or on a hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_placement(out_ch.marker_out, out_ch.placement_half);
      out_ch.ready <= !sink_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here
  initial begin
    sink_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        sink_hold <= 1'b1;
        hold_req  <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("auc_placement_counter_top: mismatch");
    $finish;
  end

  // Main sequence
  initial begin
    logic [31:0] word;
    int          n;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = apc_pkg::CMD_LOAD;
    in_ch.marker   = '0;
    in_ch.ref_slot = '0;
    in_ch.score    = '0;
    hold_req       = 1'b0;
    send_gap_pct   = 11;
    recv_stall_pct = 54;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config, one reference, tie and strict win
    send_item(apc_pkg::CMD_LOAD, '0, '0, SCORE_MIN);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MIN);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MAX);
    drain_block();
    word = $urandom();
    word[apc_pkg::CNT_W-1:0] = apc_pkg::CNT_W'(4);
    cfg_set(apc_pkg::REG_REF_COUNT, word);
    word = $urandom();
    word[0] = 1'b0;
    cfg_set(apc_pkg::REG_DIRECTION, word);

    // Extremes of the score range on marker 0, all-tie set on marker 7
    send_item(apc_pkg::CMD_LOAD, '0, apc_pkg::SLOT_W'(1), 32'hFFFF_FFFF);
    send_item(apc_pkg::CMD_LOAD, '0, apc_pkg::SLOT_W'(2), 32'h0);
    send_item(apc_pkg::CMD_LOAD, '0, apc_pkg::SLOT_W'(3), SCORE_MAX);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MIN);
    send_item(apc_pkg::CMD_QUERY, '0, '0, 32'hFFFF_FFFF);
    send_item(apc_pkg::CMD_QUERY, '0, '0, 32'h0);
    send_item(apc_pkg::CMD_QUERY, '0, '0, 32'h1);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MAX);
    for (int s = 0; s < 4; s++)
      send_item(apc_pkg::CMD_LOAD, apc_pkg::MARKER_W'(7), apc_pkg::SLOT_W'(s), SCORE_FIVE);
    send_item(apc_pkg::CMD_LOAD, apc_pkg::MARKER_W'(7),
              apc_pkg::SLOT_W'(apc_pkg::MAX_REF - 1), $urandom());
    send_item(apc_pkg::CMD_QUERY, apc_pkg::MARKER_W'(7),
              apc_pkg::SLOT_W'(apc_pkg::MAX_REF - 1), SCORE_FIVE);
    drain_block();

    // Counting references above the query
    word = $urandom();
    word[0] = 1'b1;
    cfg_set(apc_pkg::REG_DIRECTION, word);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MIN);
    send_item(apc_pkg::CMD_QUERY, '0, '0, 32'hFFFF_FFFF);
    send_item(apc_pkg::CMD_QUERY, '0, '0, 32'h0);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MAX);
    send_item(apc_pkg::CMD_QUERY, apc_pkg::MARKER_W'(7), '0, SCORE_FIVE - 32'd1);
    drain_block();

    // Full-range ref_count readback, then ref_count zero: nothing compared
    word = $urandom();
    word[apc_pkg::CNT_W-1:0] = '1;
    cfg_set(apc_pkg::REG_REF_COUNT, word);
    word = $urandom();
    word[apc_pkg::CNT_W-1:0] = '0;
    cfg_set(apc_pkg::REG_REF_COUNT, word);
    send_item(apc_pkg::CMD_QUERY, '0, '0, SCORE_MAX);
    send_item(apc_pkg::CMD_QUERY, apc_pkg::MARKER_W'(7), '0, SCORE_FIVE);
    drain_block();

    // Load the slots in use on every marker
    for (int m = 0; m < apc_pkg::MAX_MARKERS; m++)
      for (int s = 0; s < FILL; s++)
        send_item(apc_pkg::CMD_LOAD, apc_pkg::MARKER_W'(m), apc_pkg::SLOT_W'(s),
                  pick_score());

    // Random phases, each with a register setting; one idle profile per three phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      n = PHASE_REF_COUNT[p];
      drain_block();
      case (p / 3)
        0: begin
          send_gap_pct   = 11;
          recv_stall_pct = 54;
        end
        1: begin
          send_gap_pct   = 54;
          recv_stall_pct = 11;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      word = $urandom();
      word[0] = (p < 2) ? p[0] : 1'($urandom_range(1));
      cfg_set(apc_pkg::REG_DIRECTION, word);
      word = $urandom();
      word[apc_pkg::CNT_W-1:0] = n[apc_pkg::CNT_W-1:0];
      cfg_set(apc_pkg::REG_REF_COUNT, word);
      // fill the block up behind a stalled receiver
      if (p == 2) hold_req <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) random_item(n);
    end

    // Wind down
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_placements.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (sb.pending_placements.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_placements.size()));
    if (sb.errors == 0) begin
      $display("auc_placement_counter_top: match");
    end else begin
      $display("auc_placement_counter_top: mismatch");
    end
    $finish;
  end

endmodule
